@@ design/rpalu_pkg.sv @@
`timescale 1ns / 1ps
// Package for the ranked pairwise ALU: operation codes and the clip helper.
// No dependencies; used by ranked_pairwise_alu.
package rpalu_pkg;

    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_DIV     = 4'd3;
    localparam logic [3:0] OP_MOD     = 4'd4;
    localparam logic [3:0] OP_MAX     = 4'd5;
    localparam logic [3:0] OP_MIN     = 4'd6;
    localparam logic [3:0] OP_SETRANK = 4'd7;
    localparam logic [3:0] OP_AND     = 4'd8;
    localparam logic [3:0] OP_OR      = 4'd9;
    localparam logic [3:0] OP_AGEB    = 4'd10;
    localparam logic [3:0] OP_BGEA    = 4'd11;
    localparam logic [3:0] OP_NORM    = 4'd12;

    localparam logic [2:0] REG_OPERATION = 3'd0;

    // clip a 33-bit signed value to 32 bits; bit 32 of the result flags clipping
    function automatic logic [32:0] clip33(input logic signed [32:0] v);
        logic [32:0] r;
        begin
            if (v > 33'sh0_7FFF_FFFF) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end else if (v < -33'sh0_8000_0000) begin
                r = {1'b1, 32'h8000_0000};
            end else begin
                r = {1'b0, v[31:0]};
            end
            return r;
        end
    endfunction

endpackage

@@ design/ranked_pairwise_alu.sv @@
`timescale 1ns / 1ps
// Ranked pairwise ALU: pipelined fixed-point operations on ranked operand pairs.
// Depends on rpalu_pkg.
//
// Channel   | Ports            | Content
// ----------+------------------+---------------------------------------------
// input     | s_t*             | value_a, rank_a, value_b, rank_b; tlast=last_in
// result    | m_t*             | result_value, result_rank, divide_by_zero,
//           |                  | saturated; tlast=last_out
// config    | APB p*           | operation at byte address 0
//
// One transaction enters per cycle unless back-pressure reaches the input. There are
// 4 + (32 + FRACTION_BITS) register stages: capture, multiply, round,
// one stage per quotient bit of the restoring divider (the square root runs in
// the first 32 of those), then the result register. Reset is synchronous, active
// low, and empties every stage. Each stage holds while the one after it is full
// and stalled, so bubbles are squeezed out and nothing is dropped or repeated.
module ranked_pairwise_alu #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // value_a[31:0], rank_a[39:32], value_b[71:40], rank_b[79:72]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_value[31:0], result_rank[39:32],
                                   // divide_by_zero[40], saturated[41], zero pad
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = 32 + FRACTION_BITS;   // divider width
    localparam int L  = DW;                   // iteration stages
    localparam int SQ = 32;                   // square-root iterations
    localparam logic [31:0] ONE32 = 32'd1 << FRACTION_BITS;
    localparam logic [31:0] THRESH = 32'((64'd1 << FRACTION_BITS) / 64'd1000000);
    localparam logic signed [63:0] HALF64 = 64'sd1 <<< (FRACTION_BITS - 1);
    localparam logic signed [32:0] HALF33 = 33'sd1 <<< (FRACTION_BITS - 1);

    // ---------------- configuration ----------------
    logic [3:0] op_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= rpalu_pkg::OP_ADD;
        end else if (psel && penable && pwrite && pready
                     && paddr == rpalu_pkg::REG_OPERATION) begin
            op_reg <= pwdata[3:0];
        end
    end
    assign prdata = (paddr == rpalu_pkg::REG_OPERATION) ? {28'd0, op_reg} : 32'd0;

    // ---------------- handshake chain ----------------
    logic          va_reg, vb_reg, out_v_reg;
    logic [L:0]    it_v_reg;
    logic [L:0]    it_rdy;
    logic          rdy_a, rdy_b, rdy_out;

    assign rdy_out    = !out_v_reg || m_tready;
    assign it_rdy[L]  = !it_v_reg[L] || rdy_out;
    for (genvar k = 0; k < L; k++) begin : g_rdy
        assign it_rdy[k] = !it_v_reg[k] || it_rdy[k+1];
    end
    assign rdy_b    = !vb_reg || it_rdy[0];
    assign rdy_a    = !va_reg || rdy_b;
    assign s_tready = rdy_a;

    // ---------------- stage A: capture ----------------
    logic signed [31:0] a_a_reg, b_a_reg;
    logic [7:0]         ra_a_reg, rb_a_reg;
    logic               last_a_reg;
    logic [3:0]         op_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (rdy_a) begin
            va_reg <= s_tvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            a_a_reg    <= s_tdata[31:0];
            ra_a_reg   <= s_tdata[39:32];
            b_a_reg    <= s_tdata[71:40];
            rb_a_reg   <= s_tdata[79:72];
            last_a_reg <= s_tlast;
            op_a_reg   <= op_reg;
        end
    end

    // ---------------- stage B: simple ops, multiplies, divider set-up ----------------
    logic [31:0]        ua, ub;
    logic               bz;
    logic [7:0]         rank_next;
    logic [32:0]        res_next;   // {sat, value}
    logic signed [32:0] sum33, dif33, bh33, r33;

    assign ua = a_a_reg[31] ? 32'(-a_a_reg) : a_a_reg;
    assign ub = b_a_reg[31] ? 32'(-b_a_reg) : b_a_reg;
    assign bz = (b_a_reg == 32'sd0);
    assign sum33 = {a_a_reg[31], a_a_reg} + {b_a_reg[31], b_a_reg};
    assign dif33 = {a_a_reg[31], a_a_reg} - {b_a_reg[31], b_a_reg};
    assign bh33  = {b_a_reg[31], b_a_reg} + HALF33;
    assign r33   = bh33 >>> FRACTION_BITS;

    always_comb begin
        rank_next = (ra_a_reg < rb_a_reg) ? ra_a_reg : rb_a_reg;
        res_next  = 33'd0;
        case (op_a_reg)
            rpalu_pkg::OP_SUB: res_next = rpalu_pkg::clip33(dif33);
            rpalu_pkg::OP_MUL, rpalu_pkg::OP_MOD, rpalu_pkg::OP_NORM: res_next = 33'd0;
            rpalu_pkg::OP_DIV: begin
                if (bz) rank_next = 8'd0;
            end
            rpalu_pkg::OP_MAX: res_next = {1'b0, (a_a_reg > b_a_reg) ? a_a_reg : b_a_reg};
            rpalu_pkg::OP_MIN: res_next = {1'b0, (a_a_reg < b_a_reg) ? a_a_reg : b_a_reg};
            rpalu_pkg::OP_SETRANK: begin
                res_next = {1'b0, a_a_reg};
                if (!b_a_reg[31] && r33 <= 33'sd255) rank_next = r33[7:0];
                else rank_next = ra_a_reg;
            end
            rpalu_pkg::OP_AND: begin
                res_next  = {1'b0, (ua > THRESH && ub > THRESH) ? ONE32 : 32'd0};
                rank_next = 8'd255;
            end
            rpalu_pkg::OP_OR: begin
                res_next  = {1'b0, (ua > THRESH || ub > THRESH) ? ONE32 : 32'd0};
                rank_next = 8'd255;
            end
            rpalu_pkg::OP_AGEB: begin
                res_next  = {1'b0, (a_a_reg >= b_a_reg) ? ONE32 : 32'd0};
                rank_next = 8'd255;
            end
            rpalu_pkg::OP_BGEA: begin
                res_next  = {1'b0, (b_a_reg >= a_a_reg) ? ONE32 : 32'd0};
                rank_next = 8'd255;
            end
            default: res_next = rpalu_pkg::clip33(sum33);
        endcase
    end

    logic [3:0]         op_b_reg;
    logic [31:0]        res_b_reg;
    logic               sat_b_reg, last_b_reg, bz_b_reg, an_b_reg, bn_b_reg;
    logic [7:0]         rank_b_reg;
    logic signed [63:0] prod_b_reg;
    logic [63:0]        sa_b_reg, sb_b_reg;
    logic [DW-1:0]      dvd_b_reg, dvs_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (rdy_b) begin
            vb_reg <= va_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (rdy_b) begin
            op_b_reg   <= op_a_reg;
            res_b_reg  <= res_next[31:0];
            sat_b_reg  <= res_next[32];
            rank_b_reg <= rank_next;
            last_b_reg <= last_a_reg;
            bz_b_reg   <= bz;
            an_b_reg   <= a_a_reg[31];
            bn_b_reg   <= b_a_reg[31];
            prod_b_reg <= 64'(a_a_reg * b_a_reg);
            sa_b_reg   <= 64'(ua) * 64'(ua);
            sb_b_reg   <= 64'(ub) * 64'(ub);
            dvd_b_reg  <= {ua, {FRACTION_BITS{1'b0}}};
            // modulo scales both sides up by the same factor, so the remainder is scaled too
            dvs_b_reg  <= (op_a_reg == rpalu_pkg::OP_MOD) ? {ub, {FRACTION_BITS{1'b0}}}
                                                           : {{FRACTION_BITS{1'b0}}, ub};
        end
    end

    // ---------------- stage C: round the product, seed the iterations ----------------
    logic signed [63:0] mq;
    logic               mhi, mlo;

    assign mq  = (prod_b_reg + HALF64) >>> FRACTION_BITS;
    assign mhi = mq > 64'sh0000_0000_7FFF_FFFF;
    assign mlo = mq < -64'sh0000_0000_8000_0000;

    logic [3:0]    it_op_reg   [L+1];
    logic [31:0]   it_res_reg  [L+1];
    logic [7:0]    it_rank_reg [L+1];
    logic          it_sat_reg  [L+1];
    logic          it_last_reg [L+1];
    logic          it_bz_reg   [L+1];
    logic          it_an_reg   [L+1];
    logic          it_bn_reg   [L+1];
    logic [DW-1:0] it_dvd_reg  [L+1];
    logic [DW-1:0] it_dvs_reg  [L+1];
    logic [DW-1:0] it_drem_reg [L+1];
    logic [DW-1:0] it_quo_reg  [L+1];
    logic [63:0]   it_sq_reg   [L+1];
    logic [33:0]   it_srem_reg [L+1];
    logic [31:0]   it_root_reg [L+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_v_reg[0] <= 1'b0;
        end else if (it_rdy[0]) begin
            it_v_reg[0] <= vb_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (it_rdy[0]) begin
            it_op_reg[0]   <= op_b_reg;
            it_rank_reg[0] <= rank_b_reg;
            it_last_reg[0] <= last_b_reg;
            it_bz_reg[0]   <= bz_b_reg;
            it_an_reg[0]   <= an_b_reg;
            it_bn_reg[0]   <= bn_b_reg;
            it_dvd_reg[0]  <= dvd_b_reg;
            it_dvs_reg[0]  <= dvs_b_reg;
            it_drem_reg[0] <= '0;
            it_quo_reg[0]  <= '0;
            it_sq_reg[0]   <= sa_b_reg + sb_b_reg;
            it_srem_reg[0] <= '0;
            it_root_reg[0] <= '0;
            if (op_b_reg == rpalu_pkg::OP_MUL) begin
                it_res_reg[0] <= mhi ? 32'h7FFF_FFFF : (mlo ? 32'h8000_0000 : mq[31:0]);
                it_sat_reg[0] <= mhi || mlo;
            end else begin
                it_res_reg[0] <= res_b_reg;
                it_sat_reg[0] <= sat_b_reg;
            end
        end
    end

    // ---------------- iteration stages: one quotient bit, one root bit ----------------
    for (genvar k = 0; k < L; k++) begin : g_it
        logic [DW:0] drs;
        logic        dge;
        logic [35:0] srs, trial;
        logic        sge;

        assign drs   = {it_drem_reg[k], it_dvd_reg[k][DW-1]};
        assign dge   = drs >= {1'b0, it_dvs_reg[k]};
        assign srs   = {it_srem_reg[k], it_sq_reg[k][63:62]};
        assign trial = {2'b00, it_root_reg[k], 2'b01};
        assign sge   = srs >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                it_v_reg[k+1] <= 1'b0;
            end else if (it_rdy[k+1]) begin
                it_v_reg[k+1] <= it_v_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (it_rdy[k+1]) begin
                it_op_reg[k+1]   <= it_op_reg[k];
                it_res_reg[k+1]  <= it_res_reg[k];
                it_rank_reg[k+1] <= it_rank_reg[k];
                it_sat_reg[k+1]  <= it_sat_reg[k];
                it_last_reg[k+1] <= it_last_reg[k];
                it_bz_reg[k+1]   <= it_bz_reg[k];
                it_an_reg[k+1]   <= it_an_reg[k];
                it_bn_reg[k+1]   <= it_bn_reg[k];
                it_dvs_reg[k+1]  <= it_dvs_reg[k];
                it_dvd_reg[k+1]  <= {it_dvd_reg[k][DW-2:0], 1'b0};
                it_drem_reg[k+1] <= dge ? DW'(drs - {1'b0, it_dvs_reg[k]}) : drs[DW-1:0];
                it_quo_reg[k+1]  <= {it_quo_reg[k][DW-2:0], dge};
                if (k < SQ) begin
                    it_sq_reg[k+1]   <= {it_sq_reg[k][61:0], 2'b00};
                    it_srem_reg[k+1] <= sge ? 34'(srs - trial) : srs[33:0];
                    it_root_reg[k+1] <= {it_root_reg[k][30:0], sge};
                end else begin
                    it_sq_reg[k+1]   <= it_sq_reg[k];
                    it_srem_reg[k+1] <= it_srem_reg[k];
                    it_root_reg[k+1] <= it_root_reg[k];
                end
            end
        end
    end

    // ---------------- final stage: sign, round and clip the long results ----------------
    logic [DW-1:0] q;
    logic          qneg;
    logic [31:0]   mrem;
    logic [32:0]   rr;
    logic [31:0]   fin_res;
    logic          fin_sat, fin_dbz;

    assign q    = it_quo_reg[L];
    assign qneg = it_an_reg[L] ^ it_bn_reg[L];
    assign mrem = it_drem_reg[L][DW-1:FRACTION_BITS];
    assign rr   = (it_srem_reg[L] > {2'b00, it_root_reg[L]}) ? {1'b0, it_root_reg[L]} + 33'd1
                                                              : {1'b0, it_root_reg[L]};

    always_comb begin
        fin_res = it_res_reg[L];
        fin_sat = it_sat_reg[L];
        fin_dbz = 1'b0;
        case (it_op_reg[L])
            rpalu_pkg::OP_DIV: begin
                if (it_bz_reg[L]) begin
                    fin_res = 32'd0;
                    fin_dbz = 1'b1;
                end else if (!qneg) begin
                    fin_sat = q > DW'(32'h7FFF_FFFF);
                    fin_res = fin_sat ? 32'h7FFF_FFFF : q[31:0];
                end else begin
                    fin_sat = q > DW'(32'h8000_0000);
                    fin_res = fin_sat ? 32'h8000_0000 : 32'(-q[31:0]);
                end
            end
            rpalu_pkg::OP_MOD: begin
                if (it_bz_reg[L]) begin
                    fin_res = 32'd0;
                    fin_dbz = 1'b1;
                end else begin
                    fin_res = it_an_reg[L] ? 32'(-mrem) : mrem;
                end
            end
            rpalu_pkg::OP_NORM: begin
                fin_sat = rr > 33'h0_7FFF_FFFF;
                fin_res = fin_sat ? 32'h7FFF_FFFF : rr[31:0];
            end
            default: ;
        endcase
    end

    logic [31:0] out_res_reg;
    logic [7:0]  out_rank_reg;
    logic        out_dbz_reg, out_sat_reg, out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (rdy_out) begin
            out_v_reg <= it_v_reg[L];
        end
    end
    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            out_res_reg  <= fin_res;
            out_rank_reg <= it_rank_reg[L];
            out_dbz_reg  <= fin_dbz;
            out_sat_reg  <= fin_sat;
            out_last_reg <= it_last_reg[L];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'd0, out_sat_reg, out_dbz_reg, out_rank_reg, out_res_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // a zero divisor always yields a zero value
    a_dbz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40] |-> m_tdata[31:0] == 32'd0)
        else $error("divide by zero with non-zero value");
    // a zero divisor is never also a clipped result
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[40] && m_tdata[41]))
        else $error("divide_by_zero and saturated both set");
    // a flushed pipeline presents no result after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !it_v_reg[L])
        else $error("result valid straight after reset");
`endif

endmodule

@@ sim/rpalu_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the ranked pairwise ALU: watches both stream channels and the APB port,
// predicts each result from the accepted operand pair and compares it. Depends on rpalu_pkg.
module rpalu_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_results
);

    localparam int FRAC = 16;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam longint HALF = 64'sd1 << (FRAC - 1);
    localparam longint TRUE_LIMIT = ONE / 1000000;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    typedef struct packed {
        logic        last;
        logic        sat;
        logic        dbz;
        logic [7:0]  rank;
        logic [31:0] value;
    } alu_result_t;

    logic [3:0]  cur_op;
    alu_result_t expected_results[$];

    assign pending_results = expected_results.size();

    function automatic longint clamp(input longint v, inout logic sat);
        if (v > MAXV) begin
            sat = 1'b1;
            return MAXV;
        end
        if (v < MINV) begin
            sat = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    function automatic longint iabs(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= r + bitv) begin
                s = s - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic alu_result_t predict_result(input logic [3:0] op, input logic [79:0] d,
                                                   input logic lst);
        longint a, b, res, r;
        logic [7:0] ra, rb, rank;
        logic sat, dbz;
        logic [63:0] ma, mb, s, q;
        alu_result_t o;
        a = longint'($signed(d[31:0]));
        b = longint'($signed(d[71:40]));
        ra = d[39:32];
        rb = d[79:72];
        rank = ra < rb ? ra : rb;
        sat = 1'b0;
        dbz = 1'b0;
        res = 0;
        case (op)
            rpalu_pkg::OP_SUB: res = clamp(a - b, sat);
            rpalu_pkg::OP_MUL: res = clamp((a * b + HALF) >>> FRAC, sat);
            rpalu_pkg::OP_DIV: begin
                if (b == 0) begin
                    rank = 8'd0;
                    dbz = 1'b1;
                end else begin
                    res = clamp((a * ONE) / b, sat);
                end
            end
            rpalu_pkg::OP_MOD: begin
                if (b == 0) dbz = 1'b1;
                else res = a % b;
            end
            rpalu_pkg::OP_MAX: res = a > b ? a : b;
            rpalu_pkg::OP_MIN: res = a < b ? a : b;
            rpalu_pkg::OP_SETRANK: begin
                res = a;
                rank = ra;
                if (b >= 0) begin
                    r = (b + HALF) >>> FRAC;
                    if (r <= 255) rank = r[7:0];
                end
            end
            rpalu_pkg::OP_AND: begin
                res = (iabs(a) > TRUE_LIMIT && iabs(b) > TRUE_LIMIT) ? ONE : 0;
                rank = 8'd255;
            end
            rpalu_pkg::OP_OR: begin
                res = (iabs(a) > TRUE_LIMIT || iabs(b) > TRUE_LIMIT) ? ONE : 0;
                rank = 8'd255;
            end
            rpalu_pkg::OP_AGEB: begin
                res = a >= b ? ONE : 0;
                rank = 8'd255;
            end
            rpalu_pkg::OP_BGEA: begin
                res = b >= a ? ONE : 0;
                rank = 8'd255;
            end
            rpalu_pkg::OP_NORM: begin
                ma = iabs(a);
                mb = iabs(b);
                s = ma * ma + mb * mb;
                q = int_sqrt(s);
                if (s - q * q > q) q = q + 1;
                if (q > 64'h7FFF_FFFF) begin
                    res = MAXV;
                    sat = 1'b1;
                end else begin
                    res = longint'(q);
                end
            end
            default: res = clamp(a + b, sat);
        endcase
        o.value = res[31:0];
        o.rank = rank;
        o.dbz = dbz;
        o.sat = sat;
        o.last = lst;
        return o;
    endfunction

    always @(posedge aclk) begin
        alu_result_t exp_r;
        alu_result_t got;
        if (!aresetn) begin
            cur_op <= rpalu_pkg::OP_ADD;
            fail_count <= 0;
            expected_results.delete();
        end else begin
            // register writes land on the same edge as in the block
            if (psel && penable && pwrite && pready && paddr == rpalu_pkg::REG_OPERATION)
                cur_op <= pwdata[3:0];
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_result(cur_op, s_tdata, s_tlast));
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[31:0];
                got.rank = m_tdata[39:32];
                got.dbz = m_tdata[40];
                got.sat = m_tdata[41];
                got.last = m_tlast;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result transaction %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        if (fail_count < 10)
                            $display("mismatch: expected val=%h rank=%0d dbz=%b sat=%b last=%b, got val=%h rank=%0d dbz=%b sat=%b last=%b",
                                exp_r.value, exp_r.rank, exp_r.dbz, exp_r.sat, exp_r.last,
                                got.value, got.rank, got.dbz, got.sat, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ sim/tb_ranked_pairwise_alu.sv @@
`timescale 1ns / 1ps
// Testbench top for the ranked pairwise ALU: drives operand pairs and APB writes,
// gives the verdict. Depends on rpalu_pkg, rpalu_checker and ranked_pairwise_alu.
module tb_ranked_pairwise_alu;

    localparam int LATENCY = 4 + 32 + 16;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // value_a[31:0], rank_a[39:32], value_b[71:40], rank_b[79:72]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // result_value[31:0], result_rank[39:32], divide_by_zero[40],
                            // saturated[41], zero pad
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_results;
    longint      cycle_count;
    logic        stall_mode;

    ranked_pairwise_alu dut (.*);

    rpalu_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: give up if the run goes far beyond its slowest correct length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side back-pressure: mostly short stalls, a few long ones, and
    // stretches with m_tready held high.
    initial begin
        int n;
        m_tready = 1'b0;
        stall_mode = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            n = $urandom_range(0, 3) == 0 ? $urandom_range(40, 200) : $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
            if (stall_mode) begin
                n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            stall_mode = $urandom_range(0, 4) != 0;
        end
    end

    // Hold a random number of idle cycles on the input, mostly short.
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) == 0) return;
        n = $urandom_range(0, 19) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 3);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Present one operand pair and hold it until the transaction is accepted.
    task automatic send_pair(input logic [31:0] va, input logic [7:0] ra,
                             input logic [31:0] vb, input logic [7:0] rb, input logic lst);
        s_tvalid <= 1'b1;
        s_tdata <= {rb, vb, ra, va};
        s_tlast <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drain the pipeline, then write the operation register over APB.
    task automatic write_operation(input logic [3:0] op);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rpalu_pkg::REG_OPERATION;
        pwdata <= {$urandom_range(0, 1) ? 28'h0 : 28'(($urandom())), op};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_value(input logic [3:0] op);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 4)) - 2);           // around the truth threshold
            4: return 32'($urandom_range(0, 300)) << 16;               // whole numbers, rank sized
            5: return 32'($signed($urandom_range(0, 1023)) - 512) << 12; // small magnitudes
            6: return op == rpalu_pkg::OP_SETRANK
                          ? 32'($urandom_range(0, 255)) * 32'h10000 + 32'h8000
                          : $urandom();                                // rounding ties
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] edge_vals[8];
        logic [3:0]  op;
        logic [31:0] va;
        int          sent;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset operation (add): field extremes and saturation.
        edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF,
                      32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
        for (int i = 0; i < 8; i++) begin
            send_pair(edge_vals[i], 8'd255, edge_vals[7 - i], 8'd0, i[0]);
        end

        // Directed part per operation: zero divisor, ties, threshold, overflow.
        for (int o = 0; o <= 15; o++) begin
            write_operation(4'(o));
            send_pair(32'h7FFF_FFFF, 8'd3, 32'h0, 8'd200, 1'b0);
            send_pair(32'h8000_0000, 8'd255, 32'hFFFF_0000, 8'd0, 1'b1);
            send_pair(32'h0000_0001, 8'd17, 32'h0100_8000, 8'd9, 1'b0);
        end

        // Random part: change the operation between bursts.
        sent = 0;
        while (sent < 1900) begin
            op = (sent == 0) ? rpalu_pkg::OP_NORM : 4'($urandom_range(0, 15));
            write_operation(op);
            for (int k = $urandom_range(20, 80); k > 0; k--) begin
                idle_gap();
                va = rand_value(op);
                send_pair(va, 8'($urandom()), rand_value(op), 8'($urandom()),
                          1'($urandom_range(0, 7) == 0));
                sent++;
            end
            // While between 900 and 1000 pairs are sent, hold off with nothing in flight before the next burst.
            if (sent > 900 && sent < 1000) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_results != 0) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
